### rtl/lossless_jpeg_predictor_rebuild_unit_macros.svh
// Assertion macros shared by the predictor rebuild unit
`ifndef LOSSLESS_JPEG_PREDICTOR_REBUILD_UNIT_MACROS_SVH
`define LOSSLESS_JPEG_PREDICTOR_REBUILD_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LJPR_ASSERT_IMP(name, clock, rstn, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define LJPR_ASSERT_NXT(name, clock, rstn, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ljpr_pkg.sv
// Types, constants and helper functions of the predictor rebuild unit
package ljpr_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_COMPONENTS = 6;
	localparam int SAMPLE_W       = 16;
	localparam int COL_W          = $clog2(MAX_WIDTH);
	localparam int WIDTH_W        = COL_W + 1;
	localparam int COMP_W         = $clog2(MAX_COMPONENTS + 1);
	localparam int LINE_DEPTH     = MAX_WIDTH * MAX_COMPONENTS;
	localparam int LINE_AW        = $clog2(LINE_DEPTH);
	// queue depth must be a power of two, pointers wrap naturally
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = WIDTH_W;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_BITS = 3'd0,
		REG_ROW_WIDTH   = 3'd1,
		REG_COMPONENTS  = 3'd2,
		REG_SUBSAMPLED  = 3'd3,
		REG_PREDICTOR   = 3'd4
	} cfg_reg_t;

	// lossless predictor numbers
	typedef enum logic [2:0] {
		PRED_NONE       = 3'd0,
		PRED_LEFT       = 3'd1,
		PRED_ABOVE      = 3'd2,
		PRED_DIAG       = 3'd3,
		PRED_PLANE      = 3'd4,
		PRED_LEFT_GRAD  = 3'd5,
		PRED_ABOVE_GRAD = 3'd6,
		PRED_AVERAGE    = 3'd7
	} pred_sel_t;

	typedef struct packed {
		logic [4:0]         sample_bits;
		logic [WIDTH_W-1:0] row_width;
		logic [2:0]         components;
		logic [1:0]         subsampled;
		pred_sel_t          predictor;
	} cfg_t;

	// classified word handed from the front part to the back part
	typedef struct packed {
		logic [SAMPLE_W-1:0] difference;
		logic [LINE_AW-1:0]  addr;
		logic [COMP_W-1:0]   comp;
		logic                reload;
		logic                use_shared;
		logic                upd_shared;
		logic                col_zero;
		logic                use_formula;
		logic                last;
	} desc_t;

	localparam logic [4:0] SAMPLE_BITS_RESET = 5'd12;

	// half range for a sample precision, zero outside 1..16
	function automatic logic [SAMPLE_W-1:0] half_range(input logic [4:0] bits);
		logic [SAMPLE_W:0] one_hot;
		begin
			one_hot = (SAMPLE_W + 1)'(1) << (bits - 5'd1);
			if (bits >= 5'd1 && bits <= 5'd16)
				half_range = one_hot[SAMPLE_W-1:0];
			else
				half_range = '0;
		end
	endfunction

	// bits of a sample that lie above the precision
	function automatic logic [SAMPLE_W-1:0] range_mask(input logic [4:0] bits);
		begin
			if (bits < 5'd16)
				range_mask = {SAMPLE_W{1'b1}} << bits;
			else
				range_mask = '0;
		end
	endfunction

endpackage

### rtl/ljpr_ram.sv
// Generic single-write, single-read RAM with registered read data
module ljpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/ljpr_front.sv
// Front part: tracks the raster position and classifies each accepted word
module ljpr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ljpr_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      difference,
	input  logic             frame_start,
	input  logic             interval_start,
	input  logic             queue_full,
	output logic             push,
	output ljpr_pkg::desc_t  push_desc
);
	import ljpr_pkg::*;

	logic [COL_W-1:0]   col_q;
	logic [COMP_W-1:0]  comp_q;
	logic               past_q;

	logic [WIDTH_W-1:0] width_eff;
	logic [COMP_W-1:0]  comps_eff;
	logic [WIDTH_W-1:0] col0, col1, col2, col_next;
	logic [COMP_W-1:0]  c0, c1, c2, c_next;
	logic               past0, past2, past_next;
	logic [LINE_AW-1:0] addr;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	// clamp the size registers
	always_comb begin
		if (cfg.row_width == '0)
			width_eff = WIDTH_W'(1);
		else if (cfg.row_width > WIDTH_W'(MAX_WIDTH))
			width_eff = WIDTH_W'(MAX_WIDTH);
		else
			width_eff = cfg.row_width;
		if (cfg.components == '0)
			comps_eff = COMP_W'(1);
		else if (cfg.components > COMP_W'(MAX_COMPONENTS))
			comps_eff = COMP_W'(MAX_COMPONENTS);
		else
			comps_eff = cfg.components;
	end

	// place this word, then step to the next position
	always_comb begin
		col0  = frame_start ? '0 : WIDTH_W'(col_q);
		c0    = frame_start ? '0 : comp_q;
		past0 = frame_start ? 1'b0 : past_q;

		col1 = col0;
		c1   = c0;
		if (c0 >= comps_eff) begin
			c1   = '0;
			col1 = col0 + WIDTH_W'(1);
		end

		col2  = col1;
		c2    = c1;
		past2 = past0;
		if (col1 >= width_eff) begin
			col2  = '0;
			c2    = '0;
			past2 = 1'b1;
		end

		c_next    = c2 + COMP_W'(1);
		col_next  = col2;
		past_next = past2;
		if (c_next >= comps_eff) begin
			c_next   = '0;
			col_next = col2 + WIDTH_W'(1);
			if (col_next >= width_eff) begin
				col_next  = '0;
				past_next = 1'b1;
			end
		end
	end

	assign addr = LINE_AW'(col2[COL_W-1:0]) * LINE_AW'(MAX_COMPONENTS) + LINE_AW'(c2);

	// build the word for the back part
	always_comb begin
		push_desc.difference  = difference;
		push_desc.addr        = addr;
		push_desc.comp        = c2;
		push_desc.reload      = frame_start || interval_start;
		push_desc.use_shared  = (cfg.subsampled != '0) && (c2 <= COMP_W'(cfg.subsampled))
			&& ((col2 != '0) || (c2 != '0));
		push_desc.upd_shared  = c2 <= COMP_W'(cfg.subsampled);
		push_desc.col_zero    = col2 == '0;
		push_desc.use_formula = past2 && (col2 != '0);
		push_desc.last        = (col2 == width_eff - WIDTH_W'(1))
			&& (c2 == comps_eff - COMP_W'(1));
	end

	// advance the position on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			comp_q <= '0;
			past_q <= 1'b0;
		end else if (push) begin
			col_q  <= col_next[COL_W-1:0];
			comp_q <= c_next;
			past_q <= past_next;
		end
	end

endmodule

### rtl/ljpr_queue.sv
// Short queue of classified words between the front and back parts
module ljpr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ljpr_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ljpr_pkg::desc_t head_desc
);
	import ljpr_pkg::*;

	desc_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = entry_q[rd_ptr_q];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_desc;
	end

	// move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop)
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QUEUE_AW + 1)'(1);
		end
	end

endmodule

### rtl/ljpr_back.sv
// Back part: line store read, prediction, reconstruction and output register
`include "lossless_jpeg_predictor_rebuild_unit_macros.svh"
module ljpr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ljpr_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  ljpr_pkg::desc_t head_desc,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);
	import ljpr_pkg::*;

	localparam logic [SAMPLE_W-1:0] CZ_RESET = half_range(SAMPLE_BITS_RESET);

	logic                s1_valid_q;
	desc_t               desc_s1;
	logic                byp_hit_s1;
	logic [SAMPLE_W-1:0] byp_data_s1;
	logic                s1_adv;

	logic [SAMPLE_W-1:0] left_q  [MAX_COMPONENTS];
	logic [SAMPLE_W-1:0] diag_q  [MAX_COMPONENTS];
	logic [SAMPLE_W-1:0] cz_q    [MAX_COMPONENTS];
	logic [SAMPLE_W-1:0] shared_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                oor_q;
	logic                last_q;

	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] above;
	logic [SAMPLE_W-1:0] half;
	logic [SAMPLE_W-1:0] base;
	logic [SAMPLE_W-1:0] pred;
	logic [SAMPLE_W-1:0] sample_d;
	logic signed [SAMPLE_W:0] grad_left, grad_above;
	logic signed [SAMPLE_W:0] half_left, half_above;
	logic [SAMPLE_W:0]   sum_avg;

	// handshake between queue head, s1 and the output register
	assign s1_adv = s1_valid_q && (!out_valid_q || m_tready);
	assign pop    = head_valid && (!s1_valid_q || s1_adv);

	ljpr_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(desc_s1.addr),
		.wdata(sample_d),
		.re   (pop),
		.raddr(head_desc.addr),
		.rdata(ram_rdata)
	);

	assign above = byp_hit_s1 ? byp_data_s1 : ram_rdata;
	assign half  = half_range(cfg.sample_bits);

	// pick the running predictor of this component
	always_comb begin
		if (desc_s1.use_shared)
			base = shared_q;
		else if (!desc_s1.col_zero)
			base = left_q[desc_s1.comp];
		else if (desc_s1.reload)
			base = half;
		else
			base = cz_q[desc_s1.comp];
	end

	// apply the neighbour formula and add the difference
	always_comb begin
		grad_left  = $signed({1'b0, above}) - $signed({1'b0, diag_q[desc_s1.comp]});
		grad_above = $signed({1'b0, base}) - $signed({1'b0, diag_q[desc_s1.comp]});
		half_left  = grad_left >>> 1;
		half_above = grad_above >>> 1;
		sum_avg    = {1'b0, base} + {1'b0, above};
		pred       = base;
		if (desc_s1.use_formula) begin
			unique case (cfg.predictor)
				PRED_NONE:       pred = '0;
				PRED_LEFT:       pred = base;
				PRED_ABOVE:      pred = above;
				PRED_DIAG:       pred = diag_q[desc_s1.comp];
				PRED_PLANE:      pred = base + above - diag_q[desc_s1.comp];
				PRED_LEFT_GRAD:  pred = base + half_left[SAMPLE_W-1:0];
				PRED_ABOVE_GRAD: pred = above + half_above[SAMPLE_W-1:0];
				PRED_AVERAGE:    pred = sum_avg[SAMPLE_W:1];
				default:         pred = base;
			endcase
		end
		sample_d = pred + desc_s1.difference;
	end

	// load s1 and note a same-address write for the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else if (pop) begin
			s1_valid_q <= 1'b1;
			byp_hit_s1 <= s1_adv && (desc_s1.addr == head_desc.addr);
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_s1     <= head_desc;
			byp_data_s1 <= sample_d;
		end
	end

	// update the neighbour and predictor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COMPONENTS; i++) begin
				left_q[i] <= '0;
				diag_q[i] <= '0;
				cz_q[i]   <= CZ_RESET;
			end
			shared_q <= '0;
		end else if (s1_adv) begin
			// a column-0 word not on the shared predictor keeps its own sample, a reload sets the rest to half range
			for (int i = 0; i < MAX_COMPONENTS; i++) begin
				if (!desc_s1.use_shared && desc_s1.col_zero && desc_s1.comp == COMP_W'(i))
					cz_q[i] <= sample_d;
				else if (desc_s1.reload)
					cz_q[i] <= half;
			end
			left_q[desc_s1.comp] <= sample_d;
			diag_q[desc_s1.comp] <= above;
			if (desc_s1.upd_shared)
				shared_q <= sample_d;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sample_q <= sample_d;
			oor_q    <= |(sample_d & range_mask(cfg.sample_bits));
			last_q   <= desc_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sample_q;
	assign m_tuser  = oor_q;
	assign m_tlast  = last_q;

	`LJPR_ASSERT_NXT(a_s1_holds, clk, arst_n, s1_valid_q && out_valid_q && !m_tready, s1_valid_q, "s1 word dropped while output blocked")
	`LJPR_ASSERT_NXT(a_pop_fills_s1, clk, arst_n, pop, s1_valid_q, "popped word did not reach s1")
	`LJPR_ASSERT_IMP(a_out_from_s1, clk, arst_n, $rose(out_valid_q), $past(s1_valid_q), "result appeared without a word in s1")

endmodule

### rtl/lossless_jpeg_predictor_rebuild_unit.sv
// Lossless-JPEG predictor rebuild: one sample per clock sustained while neither stream
// stalls. An accepted word is written into the four-word queue, read from the line store
// as it moves from the queue head into s1, and reconstructed from s1 into the output
// register, which offers its result until it is taken. The registered read of the
// 24576 x 16 line store is why the read has a stage of its own; the neighbour and
// predictor state is updated at the same edge that moves the next word into the
// reconstruct stage, which keeps the rate at one word a cycle. The queue lets input and
// output stall on their own; write the configuration only while no word is in flight.
module lossless_jpeg_predictor_rebuild_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wen,
	input  logic [ljpr_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [ljpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // difference
	input  logic [1:0]                     s_axis_tuser,  // frame_start, interval_start
	// output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,  // sample
	output logic                           m_axis_tuser,  // out_of_range
	output logic                           m_axis_tlast   // last_of_row
);
	import ljpr_pkg::*;

	cfg_t  cfg_q;
	logic  queue_full;
	logic  push;
	desc_t push_desc;
	logic  pop;
	logic  head_valid;
	desc_t head_desc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_bits <= SAMPLE_BITS_RESET;
			cfg_q.row_width   <= WIDTH_W'(MAX_WIDTH);
			cfg_q.components  <= 3'd1;
			cfg_q.subsampled  <= 2'd0;
			cfg_q.predictor   <= PRED_LEFT;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SAMPLE_BITS: cfg_q.sample_bits <= cfg_wdata[4:0];
				REG_ROW_WIDTH:   cfg_q.row_width   <= cfg_wdata[WIDTH_W-1:0];
				REG_COMPONENTS:  cfg_q.components  <= cfg_wdata[2:0];
				REG_SUBSAMPLED:  cfg_q.subsampled  <= cfg_wdata[1:0];
				REG_PREDICTOR:   cfg_q.predictor   <= pred_sel_t'(cfg_wdata[2:0]);
				default: ;
			endcase
		end
	end

	ljpr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.difference    (s_axis_tdata),
		.frame_start   (s_axis_tuser[0]),
		.interval_start(s_axis_tuser[1]),
		.queue_full    (queue_full),
		.push          (push),
		.push_desc     (push_desc)
	);

	ljpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_desc (head_desc)
	);

	ljpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.pop       (pop),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.m_tlast   (m_axis_tlast)
	);

endmodule
